FILE: sv/ilar_pkg.sv
package ilar_pkg;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;
    localparam logic [1:0] MODE_WRITE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam int DATA_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int COUNT_W  = 9;
    localparam int GROUP_N  = 16;

    typedef struct packed {
        logic load;
        logic shift;
        logic tap;
    } t_cell_ctl;

endpackage

FILE: sv/indexed_list_append_remove_core.sv
// a result passes the cell tap, read-tree group and output registers in turn
// no new request is taken until the last one has left S_TAP and S_TREE
// append, write and remove (with its shift) update the cell row in the accept cycle
// reset: synchronous active-low i_rst_n clears the count and control; entries are not cleared
module indexed_list_append_remove_core #(
    parameter int CAPACITY = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // mode [1:0], index [9:2], value [41:10], zero [47:42]
    input  logic [47:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // read_data [31:0], count [40:32], status [42:41], zero [47:43]
    output logic [47:0] o_m_axis_tdata
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int XW    = CW + ilar_pkg::INDEX_W;
    localparam int N_TAP = (CAPACITY < 256) ? CAPACITY : 256;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_TAP  = 2'd1;
    localparam logic [1:0] S_TREE = 2'd2;

    logic [1:0]                    r_state;
    logic [1:0]                    n_state;
    logic [CW-1:0]                 r_count;
    logic [CW-1:0]                 n_count;
    logic [1:0]                    r_status;
    logic [1:0]                    n_status;
    logic                          r_m_valid;
    logic [ilar_pkg::DATA_W-1:0]   r_m_rdata;
    logic [ilar_pkg::COUNT_W-1:0]  r_m_count;
    logic [1:0]                    r_m_status;

    logic                          w_accept;
    logic [1:0]                    w_mode;
    logic [ilar_pkg::INDEX_W-1:0]  w_index;
    logic [ilar_pkg::DATA_W-1:0]   w_value;
    logic [XW-1:0]                 w_idx_ext;
    logic [XW-1:0]                 w_cnt_ext;
    logic                          w_in_range;
    logic                          w_full;
    logic                          w_do_append;
    logic                          w_do_remove;
    logic                          w_do_read;
    logic                          w_do_write;
    logic [CW-1:0]                 w_count_m1;
    logic [CW+ilar_pkg::COUNT_W-1:0] w_cnt9_ext;
    logic [ilar_pkg::DATA_W-1:0]   w_tree_data;

    logic [ilar_pkg::DATA_W-1:0]   w_cell_data [CAPACITY];
    logic [ilar_pkg::DATA_W-1:0]   w_cell_tap  [CAPACITY];
    logic [ilar_pkg::DATA_W-1:0]   w_rd_tap    [N_TAP];

    assign w_mode  = i_s_axis_tdata[1:0];
    assign w_index = i_s_axis_tdata[9:2];
    assign w_value = i_s_axis_tdata[41:10];

    assign o_s_axis_tready = i_rst_n && (r_state == S_IDLE)
                          && (!r_m_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign w_idx_ext  = {{CW{1'b0}}, w_index};
    assign w_cnt_ext  = {{ilar_pkg::INDEX_W{1'b0}}, r_count};
    assign w_in_range = w_idx_ext < w_cnt_ext;
    assign w_full     = r_count >= CW'(CAPACITY);
    assign w_count_m1 = r_count - CW'(1);

    assign w_do_append = w_accept && (w_mode == ilar_pkg::MODE_APPEND) && !w_full;
    assign w_do_remove = w_accept && (w_mode == ilar_pkg::MODE_REMOVE) && w_in_range;
    assign w_do_read   = w_accept && (w_mode == ilar_pkg::MODE_READ) && w_in_range;
    assign w_do_write  = w_accept && (w_mode == ilar_pkg::MODE_WRITE) && w_in_range;

    // cell row
    for (genvar p = 0; p < CAPACITY; p++) begin : g_cell
        localparam logic [CW-1:0] POS   = CW'(p);
        localparam logic [XW-1:0] POS_X = XW'(p);

        ilar_pkg::t_cell_ctl        w_ctl;
        logic [ilar_pkg::DATA_W-1:0] w_next;

        always_comb begin
            w_ctl.load  = (w_do_append && (r_count == POS))
                       || (w_do_write && (w_idx_ext == POS_X));
            w_ctl.shift = w_do_remove && (POS_X >= w_idx_ext) && (POS < w_count_m1);
            w_ctl.tap   = w_do_read && (w_idx_ext == POS_X);
        end

        if (p == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_data[p + 1];
        end

        ilar_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_value (w_value),
            .i_next  (w_next),
            .o_data  (w_cell_data[p]),
            .o_tap   (w_cell_tap[p])
        );
    end

    for (genvar t = 0; t < N_TAP; t++) begin : g_rd
        assign w_rd_tap[t] = w_cell_tap[t];
    end

    ilar_rdtree #(
        .N_TAP (N_TAP)
    ) u_rdtree (
        .i_clk  (i_clk),
        .i_tap  (w_rd_tap),
        .o_data (w_tree_data)
    );

    // count, status, sequencing
    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        n_state  = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_TAP;
                    if (w_mode == ilar_pkg::MODE_APPEND) begin
                        n_status = w_full ? ilar_pkg::ST_FULL : ilar_pkg::ST_OK;
                    end else begin
                        n_status = w_in_range ? ilar_pkg::ST_OK : ilar_pkg::ST_RANGE;
                    end
                    if (w_do_append) begin
                        n_count = r_count + CW'(1);
                    end else if (w_do_remove) begin
                        n_count = w_count_m1;
                    end
                end
            end
            S_TAP: begin
                n_state = S_TREE;
            end
            S_TREE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_cnt9_ext = {{ilar_pkg::COUNT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_status  <= ilar_pkg::ST_OK;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_status <= n_status;
            if (r_state == S_TREE) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_TREE) begin
            r_m_rdata  <= w_tree_data;
            r_m_count  <= w_cnt9_ext[ilar_pkg::COUNT_W-1:0];
            r_m_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {5'd0, r_m_status, r_m_count, r_m_rdata};

endmodule

FILE: sv/ilar_cell.sv
module ilar_cell (
    input  logic                          i_clk,
    input  ilar_pkg::t_cell_ctl           i_ctl,
    input  logic [ilar_pkg::DATA_W-1:0]   i_value,
    input  logic [ilar_pkg::DATA_W-1:0]   i_next,
    output logic [ilar_pkg::DATA_W-1:0]   o_data,
    output logic [ilar_pkg::DATA_W-1:0]   o_tap
);

    logic [ilar_pkg::DATA_W-1:0] r_data;
    logic [ilar_pkg::DATA_W-1:0] r_tap;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_data <= i_value;
        end else if (i_ctl.shift) begin
            r_data <= i_next;
        end
        r_tap <= i_ctl.tap ? r_data : '0;
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

FILE: sv/ilar_rdtree.sv
module ilar_rdtree #(
    parameter int N_TAP = 256
) (
    input  logic                          i_clk,
    input  logic [ilar_pkg::DATA_W-1:0]   i_tap [N_TAP],
    output logic [ilar_pkg::DATA_W-1:0]   o_data
);

    localparam int NGRP = (N_TAP + ilar_pkg::GROUP_N - 1) / ilar_pkg::GROUP_N;

    logic [ilar_pkg::DATA_W-1:0] r_grp [NGRP];

    for (genvar g = 0; g < NGRP; g++) begin : g_grp
        logic [ilar_pkg::DATA_W-1:0] w_or;

        always_comb begin
            w_or = '0;
            for (int k = 0; k < ilar_pkg::GROUP_N; k++) begin
                if (g * ilar_pkg::GROUP_N + k < N_TAP) begin
                    w_or = w_or | i_tap[g * ilar_pkg::GROUP_N + k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_grp[g] <= w_or;
        end
    end

    always_comb begin
        o_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_data = o_data | r_grp[g];
        end
    end

endmodule

FILE: sv/ilar_checker.sv
module ilar_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata
);

    logic       w_s_acc;
    logic [1:0] w_status;

    assign w_s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_status = o_m_axis_tdata[42:41];

    // one request in flight at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |=> !o_s_axis_tready)
        else $error("request accepted while busy");

    // an accepted request is followed by a valid result
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s_acc |-> ##3 o_m_axis_tvalid)
        else $error("result missing after request");

    // status code is one of ok, range, full
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ((w_status == ilar_pkg::ST_OK) || (w_status == ilar_pkg::ST_RANGE)
                             || (w_status == ilar_pkg::ST_FULL)))
        else $error("bad status code");

    // failed request reads back zero
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (w_status != ilar_pkg::ST_OK)) |-> (o_m_axis_tdata[31:0] == 32'd0))
        else $error("nonzero read data on error");

    a_hold_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind indexed_list_append_remove_core ilar_checker u_ilar_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ilar_pkg::*;

    localparam int CAP         = 256;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [DATA_W-1:0] read_data;
        logic [COUNT_W-1:0]       count;
        logic [1:0]               status;
    } t_list_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [47:0] s_data = '0;
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [47:0] m_data;

    // shadow copy of the list
    logic signed [DATA_W-1:0] shadow_entries [CAP];
    int                       shadow_count;
    t_list_result             expected_list_results [$];

    int error_count;
    int cycle_count;
    int burst_left;
    int hold_off_left;
    int stall_seg_left;
    int stall_style;
    int stall_phase;
    t_list_result want;

    indexed_list_append_remove_core #(
        .CAPACITY(CAP)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    always @(posedge clk) begin
        if (hold_off_left > 0) begin
            hold_off_left--;
            m_ready <= 1'b0;
        end else begin
            if (stall_seg_left == 0) begin
                stall_seg_left = $urandom_range(16, 160);
                stall_style = $urandom_range(0, 3);
            end
            stall_seg_left--;
            stall_phase++;
            case (stall_style)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= (stall_phase % 4 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (expected_list_results.size() == 0) begin
                $error("result with no request pending: %h", m_data);
                error_count++;
            end else begin
                want = expected_list_results.pop_front();
                if (m_data[31:0] !== want.read_data) begin
                    $error("read_data: expected %0d, actual %0d", want.read_data,
                           $signed(m_data[31:0]));
                    error_count++;
                end
                if (m_data[40:32] !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, m_data[40:32]);
                    error_count++;
                end
                if (m_data[42:41] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data[42:41]);
                    error_count++;
                end
            end
        end
    end

    function automatic void predict_list_op(input logic [1:0] mode,
                                            input logic [INDEX_W-1:0] index,
                                            input logic signed [DATA_W-1:0] value);
        t_list_result r;
        r.read_data = '0;
        r.status    = ST_OK;
        if (mode == MODE_APPEND) begin
            if (shadow_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                shadow_entries[shadow_count] = value;
                shadow_count++;
            end
        end else if (int'(index) >= shadow_count) begin
            r.status = ST_RANGE;
        end else begin
            case (mode)
                MODE_REMOVE: begin
                    for (int i = index; i + 1 < shadow_count; i++)
                        shadow_entries[i] = shadow_entries[i + 1];
                    shadow_count--;
                end
                MODE_READ: r.read_data = shadow_entries[index];
                default: shadow_entries[index] = value;
            endcase
        end
        r.count = COUNT_W'(shadow_count);
        expected_list_results.push_back(r);
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [INDEX_W-1:0] index,
                                input logic signed [DATA_W-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_data  <= {6'd0, value, index, mode};
        do @(posedge clk); while (!s_ready);
        predict_list_op(mode, index, value);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (expected_list_results.size() != 0);
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index(input int in_range_pct);
        if (shadow_count > 0 && $urandom_range(0, 99) < in_range_pct)
            return INDEX_W'($urandom_range(0, shadow_count - 1));
        return INDEX_W'($urandom_range(0, 255));
    endfunction

    task automatic send_random_op(input int append_pct, input int remove_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < append_pct)
            send_request(MODE_APPEND, INDEX_W'($urandom_range(0, 255)), pick_value());
        else if (r < append_pct + remove_pct)
            send_request(MODE_REMOVE, pick_index(85), pick_value());
        else if (r < append_pct + remove_pct + (100 - append_pct - remove_pct) / 2)
            send_request(MODE_READ, pick_index(85), pick_value());
        else
            send_request(MODE_WRITE, pick_index(85), pick_value());
    endtask

    task automatic test_directed();
        // read, remove and write out of range on an empty list
        send_request(MODE_READ, 8'd0, 32'd1);
        send_request(MODE_REMOVE, 8'd255, 32'd2);
        send_request(MODE_WRITE, 8'd0, 32'd3);
        // extremes, index ignored on append
        send_request(MODE_APPEND, 8'hff, 32'h7fff_ffff);
        send_request(MODE_APPEND, 8'h00, 32'h8000_0000);
        send_request(MODE_APPEND, 8'haa, 32'h0000_0000);
        send_request(MODE_APPEND, 8'h55, 32'hffff_ffff);
        for (int i = 0; i < 4; i++)
            send_request(MODE_READ, INDEX_W'(i), 32'd0);
        send_request(MODE_WRITE, 8'd3, 32'h5a5a_5a5a);
        send_request(MODE_READ, 8'd3, 32'd0);
        // remove first, then last
        send_request(MODE_REMOVE, 8'd0, 32'd0);
        send_request(MODE_READ, 8'd0, 32'd0);
        send_request(MODE_REMOVE, 8'd2, 32'd0);
        // index equal to count
        send_request(MODE_READ, 8'd2, 32'd0);
        send_request(MODE_WRITE, 8'd2, 32'h1234_5678);
        send_request(MODE_REMOVE, 8'd2, 32'd0);
        send_request(MODE_READ, 8'd1, 32'd0);
        wait_for_results();
    endtask

    task automatic test_random_ops(input int n);
        for (int k = 0; k < n; k++) begin
            if (shadow_count > 200)
                send_random_op(20, 35);
            else
                send_random_op(35, 20);
        end
    endtask

    task automatic test_fill_and_empty();
        while (shadow_count < CAP)
            send_request(MODE_APPEND, INDEX_W'($urandom_range(0, 255)), pick_value());
        // append on a full list
        repeat (3) send_request(MODE_APPEND, INDEX_W'($urandom_range(0, 255)), pick_value());
        send_request(MODE_READ, 8'd255, 32'd0);
        send_request(MODE_WRITE, 8'd255, 32'h8000_0001);
        send_request(MODE_READ, 8'd255, 32'd0);
        send_request(MODE_READ, 8'd0, 32'd0);
        send_request(MODE_REMOVE, 8'd255, 32'd0);
        send_request(MODE_APPEND, 8'd7, pick_value());
        send_request(MODE_REMOVE, 8'd0, 32'd0);
        send_request(MODE_READ, 8'd254, 32'd0);
        send_request(MODE_READ, 8'd255, 32'd0);
        repeat (60) send_random_op(30, 20);
        while (shadow_count > 4) begin
            if ($urandom_range(0, 4) == 0)
                send_request(MODE_READ, pick_index(80), pick_value());
            else
                send_request(MODE_REMOVE, pick_index(90), pick_value());
        end
        wait_for_results();
    endtask

    task automatic test_receiver_backpressure();
        hold_off_left = 400;
        burst_left = 1000;
        repeat (40) send_random_op(40, 20);
        wait_for_results();
    endtask

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_ops(400);
        test_receiver_backpressure();
        test_fill_and_empty();
        test_random_ops(350);
        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/ilar_pkg.sv
sv/ilar_cell.sv
sv/ilar_rdtree.sv
sv/indexed_list_append_remove_core.sv
sv/ilar_checker.sv
tb/sv/tb_top.sv
